// File: design/wea_pkg.sv
package wea_pkg;

   // register map, index of each register, byte address is 4 * index
   localparam int REG_ADDR_W = 4;
   localparam logic [1:0] REG_CHANNEL_COUNT     = 2'd0;
   localparam logic [1:0] REG_SAMPLES_PER_PIXEL = 2'd1;
   localparam logic [1:0] REG_AVERAGE_DIVISOR   = 2'd2;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 15;
   localparam int CHAN_W    = 4;
   localparam int WIN_W     = 17;
   localparam int DIV_W     = 17;
   localparam int SUM_W     = 32;

   // build constants
   localparam int MAX_WINDOW_DEFAULT   = 65536;
   localparam int MAX_CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH          = 2;

   // register reset values
   localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET     = 4'd2;
   localparam logic [WIN_W-1:0]  SAMPLES_PER_PIXEL_RESET = 17'd1024;
   localparam logic [DIV_W-1:0]  AVERAGE_DIVISOR_RESET   = 17'd512;

   // configuration seen by the front end
   typedef struct packed {
      logic [CHAN_W-1:0] channel_count;
      logic [WIN_W-1:0]  samples_per_pixel;
      logic [DIV_W-1:0]  average_divisor;
   } wea_cfg_type;

   // one finished window waiting for its division
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [DIV_W-1:0] divisor;
   } wea_job_type;

   // back end divider states
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_HOLD
   } wea_back_state_type;

endpackage

// File: design/wea_front.sv
module wea_front #(
   parameter int MAX_CHANNELS = wea_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wea_pkg::wea_cfg_type          cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wea_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic                          in_start_new,
   input  logic                          queue_full,
   output logic                          push,
   output wea_pkg::wea_job_type          push_job
);
   import wea_pkg::*;

   localparam int PHASE_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CMP_W   = 6;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [WIN_W-1:0]   pos_ff, pos_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   logic [CMP_W-1:0]   chans_eff;
   logic [WIN_W-1:0]   win_eff;
   logic [DIV_W-1:0]   div_eff;
   logic [SUM_W-1:0]   sum_cur, sum_add;
   logic [WIN_W-1:0]   pos_cur, pos_next;
   logic [PHASE_W-1:0] phase_cur;
   logic [PHASE_W:0]   phase_inc;
   logic [LEVEL_W-1:0] magnitude;
   logic               accept, window_done;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // clamp the register values into their legal ranges
   always_comb begin
      chans_eff = CMP_W'(cfg.channel_count);
      if (cfg.channel_count == '0) begin
         chans_eff = CMP_W'(1);
      end else if (CMP_W'(cfg.channel_count) > CMP_W'(MAX_CHANNELS)) begin
         chans_eff = CMP_W'(MAX_CHANNELS);
      end
      win_eff = cfg.samples_per_pixel;
      if (cfg.samples_per_pixel == '0) begin
         win_eff = WIN_W'(1);
      end else if (32'(cfg.samples_per_pixel) > 32'(MAX_WINDOW_DEFAULT)) begin
         win_eff = WIN_W'(MAX_WINDOW_DEFAULT);
      end
      div_eff = (cfg.average_divisor == '0) ? DIV_W'(1) : cfg.average_divisor;
   end

   // magnitude with the most negative sample saturated
   always_comb begin
      if (in_sample[SAMPLE_W-1]) begin
         if (in_sample[SAMPLE_W-2:0] == '0) begin
            magnitude = '1;
         end else begin
            magnitude = LEVEL_W'(-in_sample);
         end
      end else begin
         magnitude = in_sample[LEVEL_W-1:0];
      end
   end

   // window accumulation
   always_comb begin
      sum_cur   = in_start_new ? '0 : sum_ff;
      pos_cur   = in_start_new ? '0 : pos_ff;
      phase_cur = in_start_new ? '0 : phase_ff;

      sum_add   = (phase_cur == '0) ? sum_cur + SUM_W'(magnitude) : sum_cur;
      phase_inc = {1'b0, phase_cur} + 1'b1;
      pos_next  = pos_cur + 1'b1;
      window_done = (pos_next >= win_eff);

      sum_in   = sum_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (window_done) begin
            sum_in   = '0;
            pos_in   = '0;
            phase_in = '0;
         end else begin
            sum_in   = sum_add;
            pos_in   = pos_next;
            phase_in = (CMP_W'(phase_inc) >= chans_eff) ? '0 : phase_inc[PHASE_W-1:0];
         end
      end
   end

   assign push             = accept && window_done;
   assign push_job.sum     = sum_add;
   assign push_job.divisor = div_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         pos_ff   <= '0;
         phase_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: design/wea_queue.sv
module wea_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wea_pkg::wea_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output wea_pkg::wea_job_type pop_job
);
   import wea_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   wea_job_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: design/wea_back.sv
module wea_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  wea_pkg::wea_job_type         job,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [wea_pkg::LEVEL_W-1:0]  out_level
);
   import wea_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   wea_back_state_type state_ff, state_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   divisor_ff, divisor_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;
   logic               fits;
   logic               out_free;
   logic [SUM_W-1:0]   quotient;

   assign out_valid = out_valid_ff;
   assign out_level = level_ff;
   assign out_free  = !out_valid_ff || out_ready;

   // one restoring division step: shift in the next dividend bit
   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      out_valid_in = out_valid_ff && !out_ready;
      pop          = 1'b0;
      quotient     = dvd_ff;

      unique case (state_ff)
         BACK_IDLE: begin
            if (job_valid) begin
               pop        = 1'b1;
               rem_in     = '0;
               dvd_in     = job.sum;
               divisor_in = job.divisor;
               step_in    = '0;
               state_in   = BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            rem_in   = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_in   = {dvd_ff[SUM_W-2:0], fits};
            quotient = dvd_in;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  level_in     = (quotient[SUM_W-1:LEVEL_W] != '0) ? '1
                                                               : quotient[LEVEL_W-1:0];
                  state_in     = BACK_IDLE;
               end else begin
                  state_in = BACK_HOLD;
               end
            end
         end
         BACK_HOLD: begin
            // quotient parked until the output register frees up
            if (out_free) begin
               out_valid_in = 1'b1;
               level_in     = (quotient[SUM_W-1:LEVEL_W] != '0) ? '1
                                                            : quotient[LEVEL_W-1:0];
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      level_ff   <= level_in;
   end

endmodule

// File: design/waveform_envelope_averager_top.sv
// Mean-absolute envelope of the first channel of an interleaved signed 16-bit
// PCM stream. Every samples_per_pixel samples form a window; the magnitudes of
// every channel_count-th sample (starting at the window's first sample) are
// summed, and the sum divided by average_divisor gives one level, 0..32767,
// with 32767 meaning full scale. A set tuser bit on a sample restarts the
// window at that sample; a window never completed produces nothing. Samples
// are accepted one per clock while the queue is not full. Each finished
// window is handed through a two-entry queue to a bit-serial divider, which
// takes a new window only once it has finished the last one; while the
// queue is full the input is held off. Registers are written over the APB
// port at 0x0 (channel_count), 0x4 (samples_per_pixel) and 0x8
// (average_divisor) and should only be changed while the stream is idle.
module waveform_envelope_averager_top #(
   parameter int MAX_CHANNELS = wea_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [15:0] sample
   input  logic [0:0]                      req_tuser,   // [0] start_new
   // level stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,   // [14:0] level, [15] zero
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wea_pkg::REG_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import wea_pkg::*;

   logic [CHAN_W-1:0] channel_count_ff;
   logic [WIN_W-1:0]  samples_per_pixel_ff;
   logic [DIV_W-1:0]  average_divisor_ff;
   logic              csr_write;
   logic [1:0]        reg_index;

   wea_cfg_type        cfg;
   wea_job_type        push_job, pop_job;
   logic               push, pop, queue_full, pop_valid;
   logic [LEVEL_W-1:0] level;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff     <= CHANNEL_COUNT_RESET;
         samples_per_pixel_ff <= SAMPLES_PER_PIXEL_RESET;
         average_divisor_ff   <= AVERAGE_DIVISOR_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_CHANNEL_COUNT:     channel_count_ff     <= csr_pwdata[CHAN_W-1:0];
            REG_SAMPLES_PER_PIXEL: samples_per_pixel_ff <= csr_pwdata[WIN_W-1:0];
            REG_AVERAGE_DIVISOR:   average_divisor_ff   <= csr_pwdata[DIV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_index)
         REG_CHANNEL_COUNT:     csr_prdata = 32'(channel_count_ff);
         REG_SAMPLES_PER_PIXEL: csr_prdata = 32'(samples_per_pixel_ff);
         REG_AVERAGE_DIVISOR:   csr_prdata = 32'(average_divisor_ff);
         default:               csr_prdata = '0;
      endcase
   end

   assign cfg.channel_count     = channel_count_ff;
   assign cfg.samples_per_pixel = samples_per_pixel_ff;
   assign cfg.average_divisor   = average_divisor_ff;

   wea_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    (req_tdata[SAMPLE_W-1:0]),
      .in_start_new (req_tuser[0]),
      .queue_full   (queue_full),
      .push         (push),
      .push_job     (push_job)
   );

   wea_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   wea_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_level (level)
   );

   assign rsp_tdata = {1'b0, level};

endmodule

// File: design/wea_checker.sv
module wea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // no level is left pending across reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("level valid right after reset");

   // no level is valid straight after reset is released
   assert property (@(posedge clock) $past(reset) && !reset |=> !rsp_tvalid)
      else $error("level produced too soon after reset");

   // saturated level never reaches the spare top bit
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !rsp_tdata[15])
      else $error("level above full scale");

   // a stalled level holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled level changed");

endmodule

bind waveform_envelope_averager_top wea_checker u_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import wea_pkg::*;

   localparam int DRAIN_CYCLES = 150;

   // one queued sample, or a marker that holds the stream until all levels are back
   typedef struct {
      logic [15:0] sample;
      logic        start_new;
      bit          pause;
   } pcm_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = 16'h0000;   // [15:0] sample
   logic [0:0]            req_tuser = 1'b0;       // [0] start_new
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;              // [14:0] level, [15] zero
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [REG_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'h0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // register copy used by the envelope predictor
   logic [CHAN_W-1:0] cfg_chan = CHANNEL_COUNT_RESET;
   logic [WIN_W-1:0]  cfg_spp  = SAMPLES_PER_PIXEL_RESET;
   logic [DIV_W-1:0]  cfg_div  = AVERAGE_DIVISOR_RESET;

   // predictor window state
   logic [31:0] env_sum;
   logic [16:0] env_pos;
   logic [3:0]  env_phase;

   pcm_item_type pending[$];
   pcm_item_type next_item;
   logic [14:0]  levels_due[$];
   logic [14:0]  want_level;
   logic         levels_idle = 1'b1;
   int           errors = 0;
   int           req_idle_pct = 15;
   int           rsp_stall_pct = 15;

   waveform_envelope_averager_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s, got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // accumulate one sample into the window and queue a level when the window closes
   function automatic void accumulate_sample(logic [15:0] smp, logic restart);
      logic [3:0]  chans;
      logic [16:0] win;
      logic [16:0] dv;
      logic [15:0] mag;
      logic [31:0] quo;
      logic [14:0] lvl;
      chans = (cfg_chan == 0) ? 4'd1 :
              (cfg_chan > MAX_CHANNELS_DEFAULT) ? 4'(MAX_CHANNELS_DEFAULT) : cfg_chan;
      win = (cfg_spp == 0) ? 17'd1 :
            (cfg_spp > MAX_WINDOW_DEFAULT) ? 17'(MAX_WINDOW_DEFAULT) : cfg_spp;
      dv = (cfg_div == 0) ? 17'd1 : cfg_div;
      if (restart) begin
         env_sum = 32'd0;
         env_pos = 17'd0;
         env_phase = 4'd0;
      end
      // magnitude of the most negative sample saturates
      if (smp == 16'h8000) mag = 16'h7FFF;
      else if (smp[15]) mag = -smp;
      else mag = smp;
      if (env_phase == 0) env_sum = env_sum + {16'h0000, mag};
      env_phase = (env_phase + 4'd1 >= chans) ? 4'd0 : env_phase + 4'd1;
      env_pos = env_pos + 17'd1;
      // a position at or past a shrunk window also closes it
      if (env_pos >= win) begin
         quo = env_sum / {15'h0000, dv};
         lvl = (quo > 32'd32767) ? 15'h7FFF : quo[14:0];
         levels_due.insert(levels_due.size(), lvl);
         env_sum = 32'd0;
         env_pos = 17'd0;
         env_phase = 4'd0;
      end
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending.size() != 0 && pending[0].pause) begin
            req_tvalid <= 1'b0;
            if (!req_tvalid && levels_idle) void'(pending.pop_front());
         end else if (pending.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            next_item = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_item.sample;
            req_tuser <= next_item.start_new;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: predict on each sample transaction, check each level transaction
   always @(posedge clock) begin
      if (reset) begin
         env_sum = 32'd0;
         env_pos = 17'd0;
         env_phase = 4'd0;
         rsp_tready <= 1'b0;
         levels_idle <= 1'b1;
      end else begin
         if (req_tvalid && req_tready) accumulate_sample(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (levels_due.size() == 0) begin
               report_mismatch("level with none due", rsp_tdata[14:0], -1);
            end else begin
               want_level = levels_due.pop_front();
               if (rsp_tdata[14:0] !== want_level)
                  report_mismatch("level", rsp_tdata[14:0], want_level);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         levels_idle <= (levels_due.size() == 0);
      end
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_sample(logic [15:0] smp, logic restart);
      pcm_item_type item;
      item = '{smp, restart, 1'b0};
      pending.insert(pending.size(), item);
   endtask

   // hold the stream until every expected level has come back
   task automatic queue_pause();
      pcm_item_type item;
      item = '{16'h0000, 1'b0, 1'b1};
      pending.insert(pending.size(), item);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CHANNEL_COUNT:     cfg_chan = value[CHAN_W-1:0];
         REG_SAMPLES_PER_PIXEL: cfg_spp = value[WIN_W-1:0];
         REG_AVERAGE_DIVISOR:   cfg_div = value[DIV_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int chans, int spp, int dv, int idle_pct);
      write_reg(REG_CHANNEL_COUNT, chans);
      write_reg(REG_SAMPLES_PER_PIXEL, spp);
      write_reg(REG_AVERAGE_DIVISOR, dv);
      @(negedge clock);
      req_idle_pct = idle_pct;
      rsp_stall_pct = idle_pct;
   endtask

   // wait until every queued sample is taken and every level is back
   task automatic drain_stream();
      @(negedge clock);
      while (pending.size() != 0 || req_tvalid || !levels_idle) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int count, bit with_pause, int idle_pct);
      int chans;
      int spp;
      int dv;
      int eff_ch;
      case ($urandom_range(0, 9))
         0: chans = 0;
         1: chans = 15;
         2: chans = $urandom_range(9, 14);
         default: chans = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
         0: spp = 0;
         1: spp = 1;
         2: spp = $urandom_range(100, 600);
         default: spp = $urandom_range(2, 48);
      endcase
      eff_ch = (chans == 0) ? 1 : (chans > 8) ? 8 : chans;
      case ($urandom_range(0, 9))
         0: dv = 0;
         1: dv = 17'h1FFFF;
         2: dv = $urandom_range(1, 4);
         default: dv = ((spp == 0) ? 1 : spp) / eff_ch;
      endcase
      set_config(chans, spp, dv, idle_pct);
      queue_sample(pick_sample(), $urandom_range(0, 1));
      for (int i = 1; i < count; i++) begin
         if (with_pause && i == count / 2) queue_pause();
         queue_sample(pick_sample(), ($urandom_range(0, 29) == 0));
      end
      drain_stream();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // two-sample windows, divisor one: saturation of magnitude and level
      set_config(1, 2, 1, 15);
      queue_sample(16'h7FFF, 1'b1);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'h8001, 1'b0);
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'hFFFF, 1'b0);
      drain_stream();

      // zero registers fall back to one
      set_config(0, 0, 0, 15);
      queue_sample(16'h8000, 1'b1);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'hFFFF, 1'b1);
      drain_stream();

      // channel count above the limit, restart mid-window, then a partial window
      set_config(15, 9, 2, 15);
      queue_sample(pick_sample(), 1'b1);
      queue_sample(pick_sample(), 1'b0);
      queue_sample(pick_sample(), 1'b1);
      for (int i = 0; i < 11; i++) queue_sample(pick_sample(), 1'b0);
      drain_stream();

      // window shrunk below the open position: next sample closes it
      set_config(3, 2, 1, 15);
      for (int i = 0; i < 3; i++) queue_sample(pick_sample(), 1'b0);
      drain_stream();

      // random settings, one phase without any idling
      for (int p = 0; p < 8; p++) random_phase(150, p == 1 || p == 5, (p == 3) ? 0 : 15);

      // widest divisor on a short window with the channel count above the limit
      set_config(15, 40, 17'h1FFFF, 15);
      queue_sample(pick_sample(), 1'b1);
      for (int i = 1; i < 40; i++) queue_sample(pick_sample(), 1'b0);
      drain_stream();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
